// ----- hdl/qri_pkg.sv -----
// Package for the quaternion rate integrator: payload structs, sequencer
// states, fixed-point constants and the gyro cross-product term table.
// No dependencies.
`timescale 1ns / 1ps

package qri_pkg;

  localparam logic signed [31:0] ONE_Q30       = 32'sd1073741824;
  localparam logic [23:0]        STEP_TIME_RST = 24'd16777;

  typedef struct packed {
    logic               cmd;
    logic signed [23:0] rate_x;
    logic signed [23:0] rate_y;
    logic signed [23:0] rate_z;
    logic signed [31:0] load_w;
    logic signed [31:0] load_x;
    logic signed [31:0] load_y;
    logic signed [31:0] load_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] att_w;
    logic signed [31:0] att_x;
    logic signed [31:0] att_y;
    logic signed [31:0] att_z;
    logic               degenerate;
  } out_item_t;

  localparam logic CMD_GYRO = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_PREP,
    S_SCALE,
    S_SQM,
    S_SQA,
    S_SQRT_GO,
    S_SQRT,
    S_DIV_GO,
    S_DIV,
    S_DONE
  } state_t;

  localparam logic [1:0] RATE_X = 2'd0;
  localparam logic [1:0] RATE_Y = 2'd1;
  localparam logic [1:0] RATE_Z = 2'd2;

  // one term of p = q (x) (0, r): +/- q[qidx] * r[ridx]
  typedef struct packed {
    logic [1:0] qidx;
    logic [1:0] ridx;
    logic       neg;
  } term_t;

  function automatic term_t gyro_term(input logic [1:0] comp, input logic [1:0] k);
    term_t t;
    case ({comp, k})
      4'b00_00: t = '{qidx: 2'd1, ridx: RATE_X, neg: 1'b1};
      4'b00_01: t = '{qidx: 2'd2, ridx: RATE_Y, neg: 1'b1};
      4'b00_10: t = '{qidx: 2'd3, ridx: RATE_Z, neg: 1'b1};
      4'b01_00: t = '{qidx: 2'd0, ridx: RATE_X, neg: 1'b0};
      4'b01_01: t = '{qidx: 2'd2, ridx: RATE_Z, neg: 1'b0};
      4'b01_10: t = '{qidx: 2'd3, ridx: RATE_Y, neg: 1'b1};
      4'b10_00: t = '{qidx: 2'd0, ridx: RATE_Y, neg: 1'b0};
      4'b10_01: t = '{qidx: 2'd1, ridx: RATE_Z, neg: 1'b1};
      4'b10_10: t = '{qidx: 2'd3, ridx: RATE_X, neg: 1'b0};
      4'b11_00: t = '{qidx: 2'd0, ridx: RATE_Z, neg: 1'b0};
      4'b11_01: t = '{qidx: 2'd1, ridx: RATE_Y, neg: 1'b0};
      4'b11_10: t = '{qidx: 2'd2, ridx: RATE_X, neg: 1'b1};
      default:  t = '{qidx: 2'd0, ridx: RATE_X, neg: 1'b0};
    endcase
    return t;
  endfunction

endpackage

// ----- hdl/qri_mul.sv -----
// Shared 33x33 signed multiplier with registered product.
// Depends on nothing but the package convention.
`timescale 1ns / 1ps

module qri_mul (
  input  logic               clk,
  input  logic signed [32:0] mul_a,
  input  logic signed [32:0] mul_b,
  output logic signed [65:0] prod
);
  import qri_pkg::*;

  logic signed [65:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign prod = prod_r;

endmodule

// ----- hdl/qri_sqrt.sv -----
// Iterative floor square root of a 64-bit value, two result bits a cycle.
// Uses qri_pkg.
`timescale 1ns / 1ps

module qri_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  import qri_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [34:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [63:0] x_r, x_nxt;

  logic [34:0] rem_v, rem2, trial;
  logic [31:0] root_v;
  logic [63:0] x_v;

  always_comb begin
    rem_v  = rem_r;
    root_v = root_r;
    x_v    = x_r;
    rem2   = '0;
    trial  = '0;
    for (int j = 0; j < 2; j++) begin
      rem2  = {rem_v[32:0], x_v[63:62]};
      trial = {1'b0, root_v, 2'b01};
      if (rem2 >= trial) begin
        rem_v  = rem2 - trial;
        root_v = {root_v[30:0], 1'b1};
      end else begin
        rem_v  = rem2;
        root_v = {root_v[30:0], 1'b0};
      end
      x_v = {x_v[61:0], 2'b00};
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    x_nxt    = x_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '1;
      rem_nxt  = '0;
      root_nxt = '0;
      x_nxt    = radicand;
    end else if (busy_r) begin
      rem_nxt  = rem_v;
      root_nxt = root_v;
      x_nxt    = x_v;
      cnt_nxt  = cnt_r - 4'd1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    x_r    <= x_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ----- hdl/qri_div.sv -----
// Iterative restoring divider, 62-bit numerator by 32-bit divisor, two
// quotient bits a cycle. The caller keeps num < den * 2^32. Uses qri_pkg.
`timescale 1ns / 1ps

module qri_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [61:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quot
);
  import qri_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] low_r, low_nxt;
  logic [31:0] quot_r, quot_nxt;
  logic [31:0] den_r, den_nxt;

  logic [31:0] rem_v, low_v, quot_v;
  logic [32:0] rem2, diff;

  always_comb begin
    rem_v  = rem_r;
    low_v  = low_r;
    quot_v = quot_r;
    rem2   = '0;
    diff   = '0;
    for (int j = 0; j < 2; j++) begin
      rem2 = {rem_v, low_v[31]};
      diff = rem2 - {1'b0, den_r};
      if (rem2 >= {1'b0, den_r}) begin
        rem_v  = diff[31:0];
        quot_v = {quot_v[30:0], 1'b1};
      end else begin
        rem_v  = rem2[31:0];
        quot_v = {quot_v[30:0], 1'b0};
      end
      low_v = {low_v[30:0], 1'b0};
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    quot_nxt = quot_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '1;
      rem_nxt  = {2'b00, num[61:32]};
      low_nxt  = num[31:0];
      quot_nxt = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt  = rem_v;
      low_nxt  = low_v;
      quot_nxt = quot_v;
      cnt_nxt  = cnt_r - 4'd1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    low_r  <= low_nxt;
    quot_r <= quot_nxt;
    den_r  <= den_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ----- hdl/quaternion_rate_integrator_unit.sv -----
// Quaternion attitude integrator, first order, Q1.30 state. One item is
// taken at a time. The gyro step forms twenty products through one shared
// multiplier, scaling moves one bit a cycle, the squared norm is summed
// through the same multiplier, then a square root and four divides (two
// quotient bits a cycle) normalise. Results wait in an output register.
// Depends on qri_pkg, qri_mul, qri_sqrt, qri_div.
`timescale 1ns / 1ps

module quaternion_rate_integrator_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  qri_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output qri_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [23:0]        cfg_data
);
  import qri_pkg::*;

  state_t             state_r, state_nxt;
  logic [1:0]         comp_r, comp_nxt;
  logic [2:0]         k_r, k_nxt;
  in_item_t           in_r, in_nxt;
  logic [23:0]        st_r;
  logic signed [31:0] q_r [4];
  logic signed [31:0] q_nxt [4];
  logic signed [41:0] v_r [4];
  logic signed [41:0] v_nxt [4];
  logic [40:0]        mag_r [4];
  logic [40:0]        mag_nxt [4];
  logic [3:0]         neg_r, neg_nxt;
  logic [40:0]        maxm_r, maxm_nxt;
  logic signed [55:0] acc_r, acc_nxt;
  logic signed [65:0] dacc_r, dacc_nxt;
  logic [63:0]        sum_r, sum_nxt;
  logic [31:0]        n_r, n_nxt;
  logic               degen_r, degen_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic               sqrt_start, sqrt_done;
  logic [31:0]        sqrt_root;
  logic               div_start, div_done;
  logic [31:0]        div_quot;
  logic [61:0]        div_num;

  term_t              term;
  logic signed [23:0] rate_sel;
  logic signed [31:0] q_sel;
  logic signed [55:0] acc_rnd;
  logic signed [39:0] b_val;
  logic signed [65:0] dsum, dsum_rnd;
  logic signed [41:0] v_new;
  logic [40:0]        abs_v [4];
  logic [40:0]        max01, max23, max_all;
  logic [31:0]        r_sat;

  qri_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  qri_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sum_r),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  qri_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (n_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign term  = gyro_term(comp_r, k_r[1:0]);
  assign q_sel = q_r[term.qidx];

  always_comb begin
    case (term.ridx)
      RATE_X:  rate_sel = in_r.rate_x;
      RATE_Y:  rate_sel = in_r.rate_y;
      default: rate_sel = in_r.rate_z;
    endcase
  end

  // b = round(p / 2^16), split into 20 low bits and a signed high part
  assign acc_rnd = acc_r + 56'sd32768;
  assign b_val   = acc_rnd[55:16];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_SQM) begin
      mul_a = {2'b00, mag_r[comp_r][30:0]};
      mul_b = {2'b00, mag_r[comp_r][30:0]};
    end else if (k_r == 3'd3) begin
      mul_a = {13'd0, b_val[19:0]};
      mul_b = {9'd0, st_r};
    end else if (k_r == 3'd4) begin
      mul_a = {{13{b_val[39]}}, b_val[39:20]};
      mul_b = {9'd0, st_r};
    end else begin
      mul_a = {q_sel[31], q_sel};
      mul_b = {{9{rate_sel[23]}}, rate_sel};
    end
  end

  // d = round(b * dt / 2^25), v = q + d
  assign dsum     = dacc_r + (prod <<< 20);
  assign dsum_rnd = dsum + 66'sd16777216;
  assign v_new    = {{10{q_r[comp_r][31]}}, q_r[comp_r]} +
                    {dsum_rnd[65], dsum_rnd[65:25]};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      abs_v[i] = v_r[i][41] ? 41'(-v_r[i]) : v_r[i][40:0];
    end
  end

  assign max01   = (abs_v[0] > abs_v[1]) ? abs_v[0] : abs_v[1];
  assign max23   = (abs_v[2] > abs_v[3]) ? abs_v[2] : abs_v[3];
  assign max_all = (max01 > max23) ? max01 : max23;

  assign div_num = {1'b0, mag_r[comp_r][30:0], 30'd0} + {31'd0, n_r[31:1]};
  assign r_sat   = (div_quot > 32'd1073741824) ? 32'd1073741824 : div_quot;

  assign sqrt_start = (state_r == S_SQRT_GO);
  assign div_start  = (state_r == S_DIV_GO);

  always_comb begin
    state_nxt     = state_r;
    comp_nxt      = comp_r;
    k_nxt         = k_r;
    in_nxt        = in_r;
    q_nxt         = q_r;
    v_nxt         = v_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    maxm_nxt      = maxm_r;
    acc_nxt       = acc_r;
    dacc_nxt      = dacc_r;
    sum_nxt       = sum_r;
    n_nxt         = n_r;
    degen_nxt     = degen_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          in_nxt   = in_data;
          comp_nxt = '0;
          k_nxt    = '0;
          acc_nxt  = '0;
          if (in_data.cmd == CMD_LOAD) begin
            v_nxt[0]  = {{10{in_data.load_w[31]}}, in_data.load_w};
            v_nxt[1]  = {{10{in_data.load_x[31]}}, in_data.load_x};
            v_nxt[2]  = {{10{in_data.load_y[31]}}, in_data.load_y};
            v_nxt[3]  = {{10{in_data.load_z[31]}}, in_data.load_z};
            state_nxt = S_PREP;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: state_nxt = S_ACC;
      S_ACC: begin
        state_nxt = S_MUL;
        if (k_r == 3'd3) begin
          dacc_nxt = prod;
          k_nxt    = 3'd4;
        end else if (k_r == 3'd4) begin
          v_nxt[comp_r] = v_new;
          k_nxt         = '0;
          acc_nxt       = '0;
          comp_nxt      = comp_r + 2'd1;
          if (comp_r == 2'd3) state_nxt = S_PREP;
        end else begin
          acc_nxt = term.neg ? acc_r - prod[55:0] : acc_r + prod[55:0];
          k_nxt   = k_r + 3'd1;
        end
      end
      S_PREP: begin
        for (int i = 0; i < 4; i++) begin
          mag_nxt[i] = abs_v[i];
          neg_nxt[i] = v_r[i][41];
        end
        maxm_nxt = max_all;
        if (max_all == '0) begin
          q_nxt[0]  = ONE_Q30;
          q_nxt[1]  = '0;
          q_nxt[2]  = '0;
          q_nxt[3]  = '0;
          degen_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          degen_nxt = 1'b0;
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        // bring the largest magnitude into [2^30, 2^31)
        if (maxm_r[40:31] != '0) begin
          for (int i = 0; i < 4; i++) mag_nxt[i] = mag_r[i] >> 1;
          maxm_nxt = maxm_r >> 1;
        end else if (!maxm_r[30]) begin
          for (int i = 0; i < 4; i++) mag_nxt[i] = mag_r[i] << 1;
          maxm_nxt = maxm_r << 1;
        end else begin
          comp_nxt  = '0;
          sum_nxt   = '0;
          state_nxt = S_SQM;
        end
      end
      S_SQM: state_nxt = S_SQA;
      S_SQA: begin
        sum_nxt  = sum_r + prod[63:0];
        comp_nxt = comp_r + 2'd1;
        state_nxt = (comp_r == 2'd3) ? S_SQRT_GO : S_SQM;
      end
      S_SQRT_GO: state_nxt = S_SQRT;
      S_SQRT: begin
        if (sqrt_done) begin
          n_nxt     = sqrt_root;
          comp_nxt  = '0;
          state_nxt = S_DIV_GO;
        end
      end
      S_DIV_GO: state_nxt = S_DIV;
      S_DIV: begin
        if (div_done) begin
          q_nxt[comp_r] = neg_r[comp_r] ? -$signed(r_sat) : $signed(r_sat);
          comp_nxt      = comp_r + 2'd1;
          state_nxt     = (comp_r == 2'd3) ? S_DONE : S_DIV_GO;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.att_w      = q_r[0];
          out_data_nxt.att_x      = q_r[1];
          out_data_nxt.att_y      = q_r[2];
          out_data_nxt.att_z      = q_r[3];
          out_data_nxt.degenerate = degen_r;
          out_valid_nxt           = 1'b1;
          state_nxt               = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      st_r        <= STEP_TIME_RST;
      q_r[0]      <= ONE_Q30;
      q_r[1]      <= '0;
      q_r[2]      <= '0;
      q_r[3]      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      q_r         <= q_nxt;
      if (cfg_we) st_r <= cfg_data;
    end
    comp_r     <= comp_nxt;
    k_r        <= k_nxt;
    in_r       <= in_nxt;
    v_r        <= v_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    maxm_r     <= maxm_nxt;
    acc_r      <= acc_nxt;
    dacc_r     <= dacc_nxt;
    sum_r      <= sum_nxt;
    n_r        <= n_nxt;
    degen_r    <= degen_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_MUL || state_r == S_PREP))
    else $error("accepted item did not start work");

  a_result_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (state_r == S_IDLE))
    else $error("result raised while item still in work");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.att_w <= ONE_Q30 && out_data.att_w >= -ONE_Q30 &&
                   out_data.att_x <= ONE_Q30 && out_data.att_x >= -ONE_Q30 &&
                   out_data.att_y <= ONE_Q30 && out_data.att_y >= -ONE_Q30 &&
                   out_data.att_z <= ONE_Q30 && out_data.att_z >= -ONE_Q30))
    else $error("result component outside unit range");

  a_degenerate_identity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.degenerate) |->
      (out_data.att_w == ONE_Q30 && out_data.att_x == '0 &&
       out_data.att_y == '0 && out_data.att_z == '0))
    else $error("degenerate result is not the identity");

  a_one_unit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(sqrt_done && div_done))
    else $error("square root and divider finished together");

endmodule
